>>> hw/rtl/brsic_pkg.sv
// Shared constants, types and helper functions for the bit set range/intersection block.
package brsic_pkg;

  localparam int NUM_WORDS = 64;
  localparam int WORD_BITS = 64;

  localparam int ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int LEN_W  = $clog2(NUM_WORDS + 1);
  localparam int PCNT_W = $clog2(WORD_BITS + 1);
  localparam int CAP    = NUM_WORDS * WORD_BITS;

  localparam int SIZE_W  = 13;
  localparam int START_W = 12;
  localparam int END_W   = 13;
  localparam int CNT_W   = 13;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4096);

  // input codes
  localparam logic KIND_RANGE = 1'b0;
  localparam logic KIND_COUNT = 1'b1;
  localparam logic SET_A      = 1'b0;
  localparam logic SET_B      = 1'b1;

  // register indexes
  localparam logic CFG_SIZE_A = 1'b0;
  localparam logic CFG_SIZE_B = 1'b1;

  typedef struct packed {
    logic                 en_a;
    logic                 en_b;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] data;
  } brsic_wr_t;

  // word count for a set size, ceiling of size over word width, capped at the store depth
  function automatic logic [LEN_W-1:0] words_for(logic [SIZE_W-1:0] size);
    logic [SIZE_W:0] w;
    w = (SIZE_W+1)'(({1'b0, size} + (SIZE_W+1)'(WORD_BITS - 1)) / WORD_BITS);
    if (w > (SIZE_W+1)'(NUM_WORDS)) begin
      return LEN_W'(NUM_WORDS);
    end
    return LEN_W'(w);
  endfunction

  function automatic logic [PCNT_W-1:0] ones_in(logic [WORD_BITS-1:0] v);
    logic [PCNT_W-1:0] c;
    c = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      c = c + PCNT_W'(v[k]);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/bitset_range_set_intersection_count_top.sv
// Top level: command sequencer, edge mask and popcount unit around the two word stores.
//
// Two bit sets of 4096 bits each, cleared at reset. A range command sets bits
// in_range_start..in_range_end-1 of one set; a count command returns the number of
// bits set in both sets over the smaller configured word length. The block walks its
// stores one 64-bit word per cycle through a single read port, up to 64 words per command.
// A rejected range or a count over zero words answers in the cycle after it is accepted.
// busy is high while a command is in flight; each result is on out_* for exactly one cycle
// with out_valid and cannot be held off. Size registers are written through cfg_* while
// the block is idle.
module bitset_range_set_intersection_count_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic                          in_which_set,
  input  logic [brsic_pkg::START_W-1:0] in_range_start,
  input  logic [brsic_pkg::END_W-1:0]   in_range_end,
  output logic                          out_valid,
  output logic [brsic_pkg::CNT_W-1:0]   out_common_count,
  output logic                          out_range_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [brsic_pkg::SIZE_W-1:0]  cfg_data
);
  import brsic_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [SIZE_W-1:0]    size_a_r, size_a_nxt;
  logic [SIZE_W-1:0]    size_b_r, size_b_nxt;
  logic                 mode_r, mode_nxt;
  logic                 sel_r, sel_nxt;
  logic [ADDR_W-1:0]    rd_addr_r, rd_addr_nxt;
  logic [ADDR_W-1:0]    last_r, last_nxt;
  logic [ADDR_W-1:0]    first_r, first_nxt;
  logic [BIT_W-1:0]     lo_r, lo_nxt;
  logic [BIT_W-1:0]     hi_r, hi_nxt;
  logic                 pend1_r, pend1_nxt;
  logic                 pend2_r, pend2_nxt;
  logic [ADDR_W-1:0]    pend_addr_r, pend_addr_nxt;
  logic [WORD_BITS-1:0] and_r, and_nxt;
  logic [CNT_W-1:0]     acc_r, acc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 err_r, err_nxt;

  logic                 accept;
  logic [LEN_W-1:0]     len_a, len_b, len_min;
  logic [SIZE_W-1:0]    size_sel;
  logic                 range_bad;
  logic [END_W-1:0]     end_m1;
  logic [WORD_BITS-1:0] rd_a, rd_b, rd_sel;
  logic [WORD_BITS-1:0] lo_mask, hi_mask;
  logic [PCNT_W-1:0]    pcnt;
  logic [CNT_W:0]       sum;
  brsic_wr_t            wr;

  brsic_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr_r),
    .wr      (wr),
    .rd_a    (rd_a),
    .rd_b    (rd_b)
  );

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  // size writes only while idle and not colliding with a new command
  assign cfg_ready = !busy && !start;

  assign len_a    = words_for(size_a_r);
  assign len_b    = words_for(size_b_r);
  assign len_min  = (len_a < len_b) ? len_a : len_b;
  assign size_sel = (in_which_set == SET_B) ? size_b_r : size_a_r;
  assign end_m1   = in_range_end - END_W'(1);
  assign range_bad = ({1'b0, in_range_start} >= in_range_end) || (in_range_end > size_sel)
                     || (32'(in_range_end) > CAP);

  // edge masks for the word now coming out of the store
  assign lo_mask = (pend_addr_r == first_r) ? ({WORD_BITS{1'b1}} << lo_r) : '1;
  assign hi_mask = (pend_addr_r == last_r)
                   ? ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_r)) : '1;
  assign rd_sel  = (sel_r == SET_B) ? rd_b : rd_a;

  always_comb begin
    wr.en_a = pend1_r && (mode_r == KIND_RANGE) && (sel_r == SET_A);
    wr.en_b = pend1_r && (mode_r == KIND_RANGE) && (sel_r == SET_B);
    wr.addr = pend_addr_r;
    wr.data = rd_sel | (lo_mask & hi_mask);
  end

  assign pcnt = ones_in(and_r);
  assign sum  = {1'b0, acc_r} + (CNT_W+1)'(pcnt);

  always_comb begin
    state_nxt     = state_r;
    size_a_nxt    = size_a_r;
    size_b_nxt    = size_b_r;
    mode_nxt      = mode_r;
    sel_nxt       = sel_r;
    rd_addr_nxt   = rd_addr_r;
    last_nxt      = last_r;
    first_nxt     = first_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    pend1_nxt     = 1'b0;
    pend2_nxt     = pend1_r && (mode_r == KIND_COUNT);
    pend_addr_nxt = rd_addr_r;
    and_nxt       = rd_a & rd_b;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    count_nxt     = count_r;
    err_nxt       = err_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIZE_A: size_a_nxt = cfg_data;
        CFG_SIZE_B: size_b_nxt = cfg_data;
        default:    size_a_nxt = size_a_r;
      endcase
    end

    if (pend2_r) begin
      acc_nxt = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_nxt = in_kind;
          sel_nxt  = in_which_set;
          acc_nxt  = '0;
          if (in_kind == KIND_COUNT) begin
            rd_addr_nxt = '0;
            last_nxt    = ADDR_W'(len_min - LEN_W'(1));
            first_nxt   = '0;
            if (len_min == '0) begin
              out_valid_nxt = 1'b1;
              count_nxt     = '0;
              err_nxt       = 1'b0;
            end else begin
              state_nxt = ST_RUN;
            end
          end else begin
            rd_addr_nxt = ADDR_W'(in_range_start / WORD_BITS);
            first_nxt   = ADDR_W'(in_range_start / WORD_BITS);
            last_nxt    = ADDR_W'(end_m1 / WORD_BITS);
            lo_nxt      = BIT_W'(in_range_start % WORD_BITS);
            hi_nxt      = BIT_W'(end_m1 % WORD_BITS);
            if (range_bad) begin
              out_valid_nxt = 1'b1;
              count_nxt     = '0;
              err_nxt       = 1'b1;
            end else begin
              state_nxt = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        pend1_nxt = 1'b1;
        if (rd_addr_r == last_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          rd_addr_nxt = rd_addr_r + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!pend1_r && !pend2_r) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          count_nxt     = (mode_r == KIND_COUNT) ? acc_r : '0;
          err_nxt       = 1'b0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_a_r    <= SIZE_RESET;
      size_b_r    <= SIZE_RESET;
      pend1_r     <= 1'b0;
      pend2_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_a_r    <= size_a_nxt;
      size_b_r    <= size_b_nxt;
      pend1_r     <= pend1_nxt;
      pend2_r     <= pend2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    sel_r       <= sel_nxt;
    rd_addr_r   <= rd_addr_nxt;
    last_r      <= last_nxt;
    first_r     <= first_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    pend_addr_r <= pend_addr_nxt;
    and_r       <= and_nxt;
    acc_r       <= acc_nxt;
    count_r     <= count_nxt;
    err_r       <= err_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_common_count = count_r;
  assign out_range_error  = err_r;

  a_one_store_written: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr.en_a && wr.en_b))
    else $error("both stores written in one cycle");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while a command is in flight");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid_r))
    else $error("accepted command neither running nor answered");

  a_count_stage_mode: assert property (@(posedge clk) disable iff (!rst_n)
    pend2_r |-> (mode_r == KIND_COUNT))
    else $error("popcount stage active outside a count command");

endmodule

>>> hw/rtl/brsic_store.sv
// Word stores for sets A and B: one shared read address, one write port, per-word valid bits.
module brsic_store (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [brsic_pkg::ADDR_W-1:0]    rd_addr,
  input  brsic_pkg::brsic_wr_t            wr,
  output logic [brsic_pkg::WORD_BITS-1:0] rd_a,
  output logic [brsic_pkg::WORD_BITS-1:0] rd_b
);
  import brsic_pkg::*;

  logic [WORD_BITS-1:0] mem_a [NUM_WORDS];
  logic [WORD_BITS-1:0] mem_b [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid_a_r;
  logic [NUM_WORDS-1:0] valid_b_r;
  logic [WORD_BITS-1:0] rd_a_r;
  logic [WORD_BITS-1:0] rd_b_r;
  logic                 rv_a_r;
  logic                 rv_b_r;

  always_ff @(posedge clk) begin
    if (wr.en_a) begin
      mem_a[wr.addr] <= wr.data;
    end
    rd_a_r <= mem_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.en_b) begin
      mem_b[wr.addr] <= wr.data;
    end
    rd_b_r <= mem_b[rd_addr];
  end

  // a word never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= '0;
      valid_b_r <= '0;
      rv_a_r    <= 1'b0;
      rv_b_r    <= 1'b0;
    end else begin
      if (wr.en_a) begin
        valid_a_r[wr.addr] <= 1'b1;
      end
      if (wr.en_b) begin
        valid_b_r[wr.addr] <= 1'b1;
      end
      rv_a_r <= valid_a_r[rd_addr];
      rv_b_r <= valid_b_r[rd_addr];
    end
  end

  assign rd_a = rv_a_r ? rd_a_r : '0;
  assign rd_b = rv_b_r ? rd_b_r : '0;

endmodule
